// ===== src/infix_to_postfix_converter_macros.svh =====
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// Antecedent implies consequent in the same cycle, sampled on clk, off in reset.
`define I2P_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2p: implication check failed");

// Expression must never hold outside reset.
`define I2P_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("i2p: forbidden condition seen");

`endif

// ===== src/i2p_pkg.sv =====
`default_nettype none

package i2p_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;

  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_ADD  = 2'd1;
  localparam logic [1:0] RANK_MUL  = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_OPEN = 3'd5
  } op_code_t;

  typedef enum logic [2:0] {
    CLS_SKIP,
    CLS_OPERAND,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER,
    CLS_END
  } char_cls_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    op_code_t          wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } emit_t;

  function automatic char_cls_t char_class(input logic [7:0] ch);
    char_cls_t c;
    c = CLS_SKIP;
    if (ch == CH_NUL) c = CLS_END;
    else if ((ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z) ||
             (ch >= CH_DIG_0 && ch <= CH_DIG_9)) c = CLS_OPERAND;
    else if (ch == CH_OPEN) c = CLS_OPEN;
    else if (ch == CH_CLOSE) c = CLS_CLOSE;
    else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH)
      c = CLS_OPER;
    return c;
  endfunction

  function automatic op_code_t op_of_char(input logic [7:0] ch);
    op_code_t op;
    op = OP_NONE;
    if (ch == CH_PLUS) op = OP_ADD;
    else if (ch == CH_MINUS) op = OP_SUB;
    else if (ch == CH_STAR) op = OP_MUL;
    else if (ch == CH_SLASH) op = OP_DIV;
    return op;
  endfunction

  function automatic logic [1:0] rank_of(input op_code_t op);
    logic [1:0] r;
    unique case (op)
      OP_ADD, OP_SUB: r = RANK_ADD;
      OP_MUL, OP_DIV: r = RANK_MUL;
      default:        r = RANK_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(input op_code_t op);
    logic [7:0] ch;
    unique case (op)
      OP_ADD:  ch = CH_PLUS;
      OP_SUB:  ch = CH_MINUS;
      OP_MUL:  ch = CH_STAR;
      OP_DIV:  ch = CH_SLASH;
      OP_OPEN: ch = CH_OPEN;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== src/i2p_char_if.sv =====
`default_nettype none

interface i2p_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

`default_nettype wire

// ===== src/i2p_result_if.sv =====
`default_nettype none

interface i2p_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       overflow;

  modport source (output valid, output out_char, output run_last, output overflow,
                  input ready);
  modport sink   (input valid, input out_char, input run_last, input overflow,
                  output ready);
endinterface

`default_nettype wire

// ===== src/i2p_stack_mem.sv =====
`default_nettype none

module i2p_stack_mem (
  input  wire                clk,
  input  i2p_pkg::mem_req_t  req,
  output i2p_pkg::op_code_t  rd_data
);

  i2p_pkg::op_code_t store [i2p_pkg::STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      store[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= store[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/i2p_ctrl.sv =====
`default_nettype none

module i2p_ctrl (
  input  wire                           clk,
  input  wire                           rst,
  i2p_char_if.sink                      infix,
  input  wire                           out_free,
  input  i2p_pkg::op_code_t             rd_data,
  output i2p_pkg::mem_req_t             req,
  output i2p_pkg::emit_t                emit,
  output logic [i2p_pkg::CNT_W-1:0]     stack_level
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_TERM,
    S_FINISH
  } state_t;

  localparam logic [i2p_pkg::CNT_W-1:0] FULL = i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH);
  localparam logic [i2p_pkg::CNT_W-1:0] ONE  = i2p_pkg::CNT_W'(1);
  localparam logic [i2p_pkg::CNT_W-1:0] TWO  = i2p_pkg::CNT_W'(2);

  state_t                     state, state_next;
  i2p_pkg::char_cls_t         kind, kind_next;
  i2p_pkg::op_code_t          code, code_next;
  logic [i2p_pkg::CNT_W-1:0]  count, count_next;
  logic                       ovf_seen, ovf_next;
  logic                       h_valid, h_valid_next;
  logic [7:0]                 h_char, h_char_next;
  logic                       h_ovf, h_ovf_next;

  logic                       accept;
  logic                       can_emit;
  logic                       pop_it;
  logic [i2p_pkg::CNT_W-1:0]  cnt_m1;
  logic [i2p_pkg::CNT_W-1:0]  cnt_m2;
  logic                       do_push;
  logic [i2p_pkg::CNT_W-1:0]  push_at;
  i2p_pkg::op_code_t          push_code;
  logic                       do_put;
  logic [7:0]                 put_char;
  logic                       put_ovf;

  assign infix.ready = (state == S_IDLE);
  assign accept      = infix.valid && (state == S_IDLE);
  assign can_emit    = !h_valid || out_free;
  assign cnt_m1      = count - ONE;
  assign cnt_m2      = count - TWO;
  assign stack_level = count;

  always_comb begin
    pop_it = 1'b0;
    unique case (kind)
      i2p_pkg::CLS_END:   pop_it = 1'b1;
      i2p_pkg::CLS_CLOSE: pop_it = (rd_data != i2p_pkg::OP_OPEN);
      i2p_pkg::CLS_OPER:  pop_it = (i2p_pkg::rank_of(rd_data) >= i2p_pkg::rank_of(code));
      default:            pop_it = 1'b0;
    endcase
  end

  always_comb begin
    state_next   = state;
    kind_next    = kind;
    code_next    = code;
    count_next   = count;
    ovf_next     = ovf_seen;
    h_valid_next = h_valid;
    h_char_next  = h_char;
    h_ovf_next   = h_ovf;
    req          = '0;
    emit         = '0;
    do_push      = 1'b0;
    push_at      = count;
    push_code    = code;
    do_put       = 1'b0;
    put_char     = i2p_pkg::CH_NUL;
    put_ovf      = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          kind_next = i2p_pkg::char_class(infix.in_char);
          code_next = i2p_pkg::op_of_char(infix.in_char);
          unique case (i2p_pkg::char_class(infix.in_char))
            i2p_pkg::CLS_OPERAND: begin
              do_put     = 1'b1;
              put_char   = infix.in_char;
              state_next = S_FINISH;
            end
            i2p_pkg::CLS_OPEN: begin
              do_push   = 1'b1;
              push_code = i2p_pkg::OP_OPEN;
            end
            i2p_pkg::CLS_END, i2p_pkg::CLS_CLOSE, i2p_pkg::CLS_OPER: begin
              if (count != '0) begin
                req.rd_en   = 1'b1;
                req.rd_addr = cnt_m1[i2p_pkg::ADDR_W-1:0];
                state_next  = S_POP;
              end else if (i2p_pkg::char_class(infix.in_char) == i2p_pkg::CLS_END) begin
                state_next = S_TERM;
              end else if (i2p_pkg::char_class(infix.in_char) == i2p_pkg::CLS_OPER) begin
                do_push   = 1'b1;
                push_code = i2p_pkg::op_of_char(infix.in_char);
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        if (pop_it) begin
          if (can_emit) begin
            do_put     = 1'b1;
            put_char   = i2p_pkg::code_char(rd_data);
            count_next = cnt_m1;
            if (cnt_m1 != '0) begin
              // advance to the next entry down; data arrives next cycle
              req.rd_en   = 1'b1;
              req.rd_addr = cnt_m2[i2p_pkg::ADDR_W-1:0];
            end else if (kind == i2p_pkg::CLS_END) begin
              state_next = S_TERM;
            end else begin
              if (kind == i2p_pkg::CLS_OPER) begin
                do_push = 1'b1;
                push_at = cnt_m1;
              end
              state_next = S_FINISH;
            end
          end
        end else begin
          if (kind == i2p_pkg::CLS_CLOSE) begin
            // drop the matching open parenthesis
            count_next = cnt_m1;
          end else begin
            do_push = 1'b1;
          end
          state_next = S_FINISH;
        end
      end
      S_TERM: begin
        if (can_emit) begin
          do_put     = 1'b1;
          put_char   = i2p_pkg::CH_NUL;
          put_ovf    = ovf_seen;
          ovf_next   = 1'b0;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!h_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          emit.valid   = 1'b1;
          emit.ch      = h_char;
          emit.ovf     = h_ovf;
          emit.last    = 1'b1;
          h_valid_next = 1'b0;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // the held result goes out once a successor is known to exist
    if (do_put) begin
      if (h_valid) begin
        emit.valid = 1'b1;
        emit.ch    = h_char;
        emit.ovf   = h_ovf;
        emit.last  = 1'b0;
      end
      h_valid_next = 1'b1;
      h_char_next  = put_char;
      h_ovf_next   = put_ovf;
    end

    if (do_push) begin
      if (push_at == FULL) begin
        ovf_next = 1'b1;
      end else begin
        req.wr_en   = 1'b1;
        req.wr_addr = push_at[i2p_pkg::ADDR_W-1:0];
        req.wr_data = push_code;
        count_next  = push_at + ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      ovf_seen <= 1'b0;
      h_valid  <= 1'b0;
      kind     <= i2p_pkg::CLS_SKIP;
      code     <= i2p_pkg::OP_NONE;
    end else begin
      state    <= state_next;
      count    <= count_next;
      ovf_seen <= ovf_next;
      h_valid  <= h_valid_next;
      kind     <= kind_next;
      code     <= code_next;
    end
    h_char <= h_char_next;
    h_ovf  <= h_ovf_next;
  end

endmodule

`default_nettype wire

// ===== src/infix_to_postfix_converter.sv =====
// Infix to postfix converter (shunting-yard), one ASCII character per request.
// Channel infix: valid/ready with in_char; code 0 ends the expression.
// Channel postfix: valid/ready with out_char, run_last and overflow. Letters and
// digits are echoed, operators come out in postfix order, and the end of an
// expression flushes the operator stack followed by a 0 terminator whose
// overflow bit reports any push dropped for a full stack since the last one.
// run_last marks the final result caused by each request.
// The operator stack sits in a synchronous memory, so a read returns its entry in
// the cycle after it is issued; a request that pops first reads the top entry,
// then emits each popped operator while it reads the entry below, an operand
// passes through S_FINISH, and an end of expression ends in S_TERM, which emits
// the 0 terminator.
// One request is worked on at a time; infix.ready is high only between requests.
// Results leave through an output register: a stalled receiver holds the current
// result and freezes the sequencer, while infix may still take the next request
// once the previous one has handed over its final result.
// Reset (rst, synchronous) empties the stack, clears the overflow flag and drops
// any pending result; no clearing pass is needed.
`default_nettype none

`include "infix_to_postfix_converter_macros.svh"

module infix_to_postfix_converter (
  input  wire          clk,
  input  wire          rst,
  i2p_char_if.sink     infix,
  i2p_result_if.source postfix
);

  i2p_pkg::mem_req_t              req;
  i2p_pkg::op_code_t              rd_data;
  i2p_pkg::emit_t                 emit;
  logic [i2p_pkg::CNT_W-1:0]      stack_level;

  logic                           out_valid;
  logic [7:0]                     out_char;
  logic                           out_last;
  logic                           out_ovf;
  logic                           out_free;

  assign out_free = !out_valid || postfix.ready;

  i2p_stack_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  i2p_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .infix       (infix),
    .out_free    (out_free),
    .rd_data     (rd_data),
    .req         (req),
    .emit        (emit),
    .stack_level (stack_level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (postfix.ready) begin
      out_valid <= 1'b0;
    end
    if (emit.valid) begin
      out_char <= emit.ch;
      out_last <= emit.last;
      out_ovf  <= emit.ovf;
    end
  end

  assign postfix.valid    = out_valid;
  assign postfix.out_char = out_char;
  assign postfix.run_last = out_last;
  assign postfix.overflow = out_ovf;

  `I2P_ASSERT_NEVER(a_stack_bound, stack_level > i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH))
  `I2P_ASSERT_IMPLY(a_no_overrun, emit.valid, out_free)
  `I2P_ASSERT_IMPLY(a_ovf_on_term, postfix.valid && postfix.out_char != 8'd0, !postfix.overflow)
  `I2P_ASSERT_IMPLY(a_term_last, postfix.valid && postfix.out_char == 8'd0, postfix.run_last)

endmodule

`default_nettype wire

// ===== bench/postfix_checker.sv =====
`timescale 1ns / 100ps

module postfix_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  input  wire        in_ready,
  input  wire  [7:0] in_char,
  input  wire        out_valid,
  input  wire        out_ready,
  input  wire  [7:0] out_char,
  input  wire        out_last,
  input  wire        out_ovf,
  output int         fault_count,
  output int         backlog
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } postfix_sym_t;

  i2p_pkg::op_code_t op_stack [i2p_pkg::STACK_DEPTH];
  int unsigned       stack_used;
  logic              ovf_pending;
  postfix_sym_t      awaited_q [$];

  function automatic logic [1:0] precedence(input i2p_pkg::op_code_t op);
    case (op)
      i2p_pkg::OP_ADD, i2p_pkg::OP_SUB: return i2p_pkg::RANK_ADD;
      i2p_pkg::OP_MUL, i2p_pkg::OP_DIV: return i2p_pkg::RANK_MUL;
      default:                          return i2p_pkg::RANK_NONE;
    endcase
  endfunction

  function automatic logic [7:0] symbol_of(input i2p_pkg::op_code_t op);
    case (op)
      i2p_pkg::OP_ADD:  return i2p_pkg::CH_PLUS;
      i2p_pkg::OP_SUB:  return i2p_pkg::CH_MINUS;
      i2p_pkg::OP_MUL:  return i2p_pkg::CH_STAR;
      i2p_pkg::OP_DIV:  return i2p_pkg::CH_SLASH;
      i2p_pkg::OP_OPEN: return i2p_pkg::CH_OPEN;
      default:          return i2p_pkg::CH_NUL;
    endcase
  endfunction

  task automatic queue_sym(input logic [7:0] ch, input logic ovf);
    postfix_sym_t s;
    s.ch   = ch;
    s.last = 1'b0;
    s.ovf  = ovf;
    awaited_q.push_back(s);
  endtask

  task automatic pop_to_output();
    stack_used--;
    queue_sym(symbol_of(op_stack[i2p_pkg::ADDR_W'(stack_used)]), 1'b0);
  endtask

  task automatic push_op(input i2p_pkg::op_code_t op);
    // a full stack drops the push and remembers it for the terminator
    if (stack_used >= i2p_pkg::STACK_DEPTH) begin
      ovf_pending = 1'b1;
    end else begin
      op_stack[i2p_pkg::ADDR_W'(stack_used)] = op;
      stack_used++;
    end
  endtask

  task automatic convert_char(input logic [7:0] ch);
    int unsigned       base;
    i2p_pkg::op_code_t op;
    base = awaited_q.size();
    op   = i2p_pkg::OP_NONE;
    if (ch == i2p_pkg::CH_NUL) begin
      while (stack_used > 0) pop_to_output();
      queue_sym(i2p_pkg::CH_NUL, ovf_pending);
      ovf_pending = 1'b0;
    end else if ((ch >= i2p_pkg::CH_UP_A && ch <= i2p_pkg::CH_UP_Z) ||
                 (ch >= i2p_pkg::CH_LO_A && ch <= i2p_pkg::CH_LO_Z) ||
                 (ch >= i2p_pkg::CH_DIG_0 && ch <= i2p_pkg::CH_DIG_9)) begin
      queue_sym(ch, 1'b0);
    end else if (ch == i2p_pkg::CH_OPEN) begin
      push_op(i2p_pkg::OP_OPEN);
    end else if (ch == i2p_pkg::CH_CLOSE) begin
      while (stack_used > 0 &&
             op_stack[i2p_pkg::ADDR_W'(stack_used - 1)] != i2p_pkg::OP_OPEN)
        pop_to_output();
      // drop the matching open bracket, if there is one
      if (stack_used > 0) stack_used--;
    end else begin
      case (ch)
        i2p_pkg::CH_PLUS:  op = i2p_pkg::OP_ADD;
        i2p_pkg::CH_MINUS: op = i2p_pkg::OP_SUB;
        i2p_pkg::CH_STAR:  op = i2p_pkg::OP_MUL;
        i2p_pkg::CH_SLASH: op = i2p_pkg::OP_DIV;
        default:           op = i2p_pkg::OP_NONE;
      endcase
      if (op != i2p_pkg::OP_NONE) begin
        while (stack_used > 0 &&
               precedence(op_stack[i2p_pkg::ADDR_W'(stack_used - 1)]) >= precedence(op))
          pop_to_output();
        push_op(op);
      end
    end
    if (awaited_q.size() > base) awaited_q[awaited_q.size()-1].last = 1'b1;
  endtask

  task automatic check_sym(input postfix_sym_t got);
    postfix_sym_t want;
    if (awaited_q.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("postfix: result with nothing awaited: ch=%02h last=%0b ovf=%0b",
                 got.ch, got.last, got.ovf);
    end else begin
      want = awaited_q.pop_front();
      if (want != got) begin
        fault_count++;
        if (fault_count <= 10)
          $display("postfix: expected ch=%02h last=%0b ovf=%0b, got ch=%02h last=%0b ovf=%0b",
                   want.ch, want.last, want.ovf, got.ch, got.last, got.ovf);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stack_used  = 0;
      ovf_pending = 1'b0;
      fault_count = 0;
      awaited_q.delete();
    end else begin
      if (in_valid && in_ready) convert_char(in_char);
      if (out_valid && out_ready) check_sym({out_char, out_last, out_ovf});
    end
    backlog <= awaited_q.size();
  end

endmodule

// ===== bench/infix_to_postfix_converter_tb.sv =====
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb;

  localparam int RANDOM_ITEMS = 360;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE       = 40;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic rx_ready = 1'b0;

  int fault_count;
  int backlog;
  int items_sent;
  int burst_left;
  int idle_cycles = 0;

  rx_mode_t rx_mode   = RX_FREE;
  int       mode_left = 0;
  int       hold_left = 0;

  i2p_char_if   infix_ch ();
  i2p_result_if postfix_ch ();

  assign postfix_ch.ready = rx_ready;

  infix_to_postfix_converter dut (
    .clk     (clk),
    .rst     (rst),
    .infix   (infix_ch),
    .postfix (postfix_ch)
  );

  postfix_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (infix_ch.valid),
    .in_ready    (infix_ch.ready),
    .in_char     (infix_ch.in_char),
    .out_valid   (postfix_ch.valid),
    .out_ready   (postfix_ch.ready),
    .out_char    (postfix_ch.out_char),
    .out_last    (postfix_ch.run_last),
    .out_ovf     (postfix_ch.overflow),
    .fault_count (fault_count),
    .backlog     (backlog)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls: switch between free running, coin toss, sparse and long holds
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_FREE:   rx_ready <= 1'b1;
      RX_COIN:   rx_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: rx_ready <= (mode_left % 4 == 0);
      default: begin
        if (hold_left > 0) begin
          rx_ready  <= 1'b0;
          hold_left <= hold_left - 1;
        end else begin
          rx_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) hold_left <= $urandom_range(5, 20);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if ((infix_ch.valid && infix_ch.ready) || (postfix_ch.valid && postfix_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] ch);
    int gap;
    infix_ch.valid   <= 1'b1;
    infix_ch.in_char <= ch;
    @(posedge clk);
    while (!infix_ch.ready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        infix_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold the sender until every awaited result has come back
  task automatic drain();
    infix_ch.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_operand();
    int r;
    r = $urandom_range(0, 61);
    if (r < 26) return 8'(i2p_pkg::CH_UP_A + r);
    if (r < 52) return 8'(i2p_pkg::CH_LO_A + (r - 26));
    return 8'(i2p_pkg::CH_DIG_0 + (r - 52));
  endfunction

  function automatic logic [7:0] any_operator();
    case ($urandom_range(0, 3))
      0:       return i2p_pkg::CH_PLUS;
      1:       return i2p_pkg::CH_MINUS;
      2:       return i2p_pkg::CH_STAR;
      default: return i2p_pkg::CH_SLASH;
    endcase
  endfunction

  task automatic send_expression();
    int terms;
    int open_n;
    terms  = $urandom_range(1, 8);
    open_n = 0;
    for (int i = 0; i < terms; i++) begin
      while (open_n < 6 && $urandom_range(0, 3) == 0) begin
        send_char(i2p_pkg::CH_OPEN);
        open_n++;
      end
      send_char(any_operand());
      if ($urandom_range(0, 15) == 0) send_char(8'h20);
      while (open_n > 0 && $urandom_range(0, 2) == 0) begin
        send_char(i2p_pkg::CH_CLOSE);
        open_n--;
      end
      if (i < terms - 1) send_char(any_operator());
    end
    while (open_n > 0) begin
      send_char(i2p_pkg::CH_CLOSE);
      open_n--;
    end
    send_char(i2p_pkg::CH_NUL);
  endtask

  // nest 12 to 22 brackets deep, which can fill the stack, with operators mixed in
  task automatic send_deep_nest();
    int n;
    n = $urandom_range(12, 22);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_char(any_operand());
        send_char(any_operator());
      end
      send_char(i2p_pkg::CH_OPEN);
    end
    send_char(any_operand());
    repeat ($urandom_range(0, 6)) send_char(i2p_pkg::CH_CLOSE);
    send_char(i2p_pkg::CH_NUL);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(2, 16)) send_char(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) == 0) send_char(i2p_pkg::CH_NUL);
  endtask

  initial begin
    string lead;
    lead = "A*(z-9)+)";
    rst              <= 1'b1;
    infix_ch.valid   <= 1'b0;
    infix_ch.in_char <= i2p_pkg::CH_NUL;
    burst_left = 0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // mixed precedence, brackets, an unmatched close and an ignored code
    for (int i = 0; i < lead.len(); i++) send_char(lead[i]);
    send_char(8'hFF);
    send_char(i2p_pkg::CH_NUL);
    // one push more than the stack holds
    send_char(i2p_pkg::CH_LO_A);
    send_char(i2p_pkg::CH_SLASH);
    repeat (i2p_pkg::STACK_DEPTH) send_char(i2p_pkg::CH_OPEN);
    send_char(i2p_pkg::CH_NUL);
    send_char(i2p_pkg::CH_DIG_0);
    send_char(i2p_pkg::CH_UP_Z);
    send_char(i2p_pkg::CH_NUL);
    drain();

    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2: send_deep_nest();
        3, 4, 5: send_noise();
        default: send_expression();
      endcase
      if ($urandom_range(0, 14) == 0) drain();
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fault_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== infix_to_postfix_converter.f =====
+incdir+src
src/i2p_pkg.sv
src/i2p_char_if.sv
src/i2p_result_if.sv
src/i2p_stack_mem.sv
src/i2p_ctrl.sv
src/infix_to_postfix_converter.sv
bench/postfix_checker.sv
bench/infix_to_postfix_converter_tb.sv
